// File: rtl/mtg_pkg.sv
// shared constants for the mt19937 word generator
package mtg_pkg;

    localparam int unsigned StateWords   = 624;
    localparam int unsigned MiddleOffset = 397;

    localparam logic [31:0] TwistMatrix  = 32'h9908_B0DF;
    localparam logic [31:0] SeedMult     = 32'd69069;
    localparam logic [31:0] TemperB      = 32'h9D2C_5680;
    localparam logic [31:0] TemperC      = 32'hEFC6_0000;
    localparam logic [31:0] DefaultSeed  = 32'd4357;
    localparam logic [31:0] UpperMask    = 32'h8000_0000;
    localparam logic [31:0] LowerMask    = 32'h7FFF_FFFF;

    // input item mode codes
    localparam logic ModeSeed     = 1'b0;
    localparam logic ModeGenerate = 1'b1;

endpackage

// File: rtl/mersenne_twister_generator.sv
// mt19937 generator top level: control sequencer around the state word ram
// generate item: current, next and middle words are captured in S_RD1, S_RD2 and S_WB; write-back
//   and result wait on a stalled output; the single-read-port state ram forces the three reads
// seed item: one word written per cycle over all STATE_WORDS words; no result
// first generate item after reset also runs the seed sweep with the default seed
// reset clears control only; ram contents stay undefined until seeded
module mersenne_twister_generator #(
    parameter int unsigned STATE_WORDS   = mtg_pkg::StateWords,
    parameter int unsigned MIDDLE_OFFSET = mtg_pkg::MiddleOffset
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [31:0] i_seed_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_random_word
);
    import mtg_pkg::*;

    localparam int unsigned AW = $clog2(STATE_WORDS);
    localparam logic [AW-1:0] LastIdx = AW'(STATE_WORDS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SEED = 5'b00010,
        S_RD1  = 5'b00100,
        S_RD2  = 5'b01000,
        S_WB   = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_k, n_k;
    logic        r_seeded, n_seeded;
    logic        r_gen_pend, n_gen_pend;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_x, n_x;
    logic [31:0] r_cur, r_nxt_word;
    logic [31:0] r_out_word;

    logic          in_acc;
    logic          out_acc;
    logic          wb_go;
    logic [AW:0]   pos_inc;
    logic [AW:0]   mid_sum;
    logic [AW-1:0] nxt_idx;
    logic [AW-1:0] mid_idx;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic [31:0]   new_word;
    logic [31:0]   tempered;

    // handshakes
    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;
    assign wb_go   = (r_state == S_WB) && (!r_out_valid || !i_stall);

    // neighbor indexes with wrap
    always_comb begin
        pos_inc = {1'b0, r_pos} + (AW+1)'(1);
        mid_sum = {1'b0, r_pos} + (AW+1)'(MIDDLE_OFFSET);
        nxt_idx = (r_pos == LastIdx) ? '0 : pos_inc[AW-1:0];
        if (mid_sum >= (AW+1)'(STATE_WORDS)) begin
            mid_idx = AW'(mid_sum - (AW+1)'(STATE_WORDS));
        end else begin
            mid_idx = mid_sum[AW-1:0];
        end
    end

    // ram port control; the middle word stays addressed while write-back waits
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = new_word;
        ram_raddr = r_pos;
        unique case (r_state)
            S_IDLE: ram_raddr = r_pos;
            S_SEED: begin
                ram_we    = 1'b1;
                ram_waddr = r_k;
                ram_wdata = r_x;
                ram_raddr = '0;
            end
            S_RD1:  ram_raddr = nxt_idx;
            S_RD2:  ram_raddr = mid_idx;
            S_WB: begin
                ram_we    = wb_go;
                ram_raddr = mid_idx;
            end
            default: ram_raddr = r_pos;
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_k         = r_k;
        n_seeded    = r_seeded;
        n_gen_pend  = r_gen_pend;
        n_out_valid = r_out_valid && !out_acc;
        n_x         = r_x;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_k = '0;
                    if (i_mode == ModeSeed) begin
                        n_x        = i_seed_value | 32'h1;
                        n_gen_pend = 1'b0;
                        n_state    = S_SEED;
                    end else if (!r_seeded) begin
                        n_x        = DefaultSeed | 32'h1;
                        n_gen_pend = 1'b1;
                        n_state    = S_SEED;
                    end else begin
                        n_state = S_RD1;
                    end
                end
            end
            S_SEED: begin
                n_x = r_x * SeedMult;
                n_k = r_k + AW'(1);
                if (r_k == LastIdx) begin
                    n_pos      = '0;
                    n_seeded   = 1'b1;
                    n_gen_pend = 1'b0;
                    n_state    = r_gen_pend ? S_RD1 : S_IDLE;
                end
            end
            S_RD1: n_state = S_RD2;
            S_RD2: n_state = S_WB;
            S_WB: begin
                if (wb_go) begin
                    n_out_valid = 1'b1;
                    n_pos       = nxt_idx;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_k         <= '0;
            r_seeded    <= 1'b0;
            r_gen_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_k         <= n_k;
            r_seeded    <= n_seeded;
            r_gen_pend  <= n_gen_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers: seed chain, fetched words, output word
    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        if (r_state == S_RD1) begin
            r_cur <= ram_rdata;
        end
        if (r_state == S_RD2) begin
            r_nxt_word <= ram_rdata;
        end
        if (wb_go) begin
            r_out_word <= tempered;
        end
    end

    mtg_ram #(
        .WIDTH(32),
        .DEPTH(STATE_WORDS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    mtg_twist u_twist (
        .i_cur     (r_cur),
        .i_nxt     (r_nxt_word),
        .i_mid     (ram_rdata),
        .o_new_word(new_word),
        .o_tempered(tempered)
    );

    assign o_valid       = r_out_valid;
    assign o_random_word = r_out_word;

endmodule

// File: rtl/mtg_ram.sv
// generic single-write, single-read ram with registered read data
module mtg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mtg_twist.sv
// twist recurrence for one state word and output tempering
module mtg_twist (
    input  logic [31:0] i_cur,
    input  logic [31:0] i_nxt,
    input  logic [31:0] i_mid,
    output logic [31:0] o_new_word,
    output logic [31:0] o_tempered
);
    import mtg_pkg::*;

    logic [31:0] y;
    logic [31:0] v;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;

    // combine upper bit of current with lower bits of next, then twist
    always_comb begin
        y  = (i_cur & UpperMask) | (i_nxt & LowerMask);
        v  = i_mid ^ (y >> 1) ^ (y[0] ? TwistMatrix : 32'h0);
        t1 = v ^ (v >> 11);
        t2 = t1 ^ ((t1 << 7) & TemperB);
        t3 = t2 ^ ((t2 << 15) & TemperC);
    end

    assign o_new_word = v;
    assign o_tempered = t3 ^ (t3 >> 18);

endmodule
